// ===== sv/iosrw_pkg.sv =====
// ============================================================================
// iosrw_pkg
// Shared types and constants of the in-order signature reorder window.
// ============================================================================
package iosrw_pkg;

    localparam int unsigned IDX_W       = 8;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned ELEM_W      = 8 * WORD_W;
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [IDX_W-1:0] CPS_RESET = 8'd67;

    // One input word: chain index plus the eight element words.
    typedef struct packed {
        logic [IDX_W-1:0]  chain_index;
        logic [WORD_W-1:0] word_0;
        logic [WORD_W-1:0] word_1;
        logic [WORD_W-1:0] word_2;
        logic [WORD_W-1:0] word_3;
        logic [WORD_W-1:0] word_4;
        logic [WORD_W-1:0] word_5;
        logic [WORD_W-1:0] word_6;
        logic [WORD_W-1:0] word_7;
    } t_in;

    // Element body as it sits in the window memory.
    typedef struct packed {
        logic [WORD_W-1:0] word_0;
        logic [WORD_W-1:0] word_1;
        logic [WORD_W-1:0] word_2;
        logic [WORD_W-1:0] word_3;
        logic [WORD_W-1:0] word_4;
        logic [WORD_W-1:0] word_5;
        logic [WORD_W-1:0] word_6;
        logic [WORD_W-1:0] word_7;
    } t_elem;

    // One result word.
    typedef struct packed {
        logic [WORD_W-1:0] out_word_0;
        logic [WORD_W-1:0] out_word_1;
        logic [WORD_W-1:0] out_word_2;
        logic [WORD_W-1:0] out_word_3;
        logic [WORD_W-1:0] out_word_4;
        logic [WORD_W-1:0] out_word_5;
        logic [WORD_W-1:0] out_word_6;
        logic [WORD_W-1:0] out_word_7;
        logic              last_of_run;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_EVAL,
        ST_DONE
    } t_state;

endpackage

// ===== sv/iosrw_ram.sv =====
// ============================================================================
// iosrw_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module iosrw_ram #(
    parameter int unsigned WIDTH = 264,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/in_order_signature_reorder_window_core.sv =====
// ============================================================================
// in_order_signature_reorder_window_core
// Reorder window that releases one signature's chain elements in index order.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one element
//   word: chain index plus eight 32-bit words. The element lands in window
//   slot (index mod WINDOW_DEPTH) of the element memory with its index as tag.
//   The block then drains: every slot holding the expected index is sent
//   on the output channel (o_out_valid / i_out_stall / o_out_data) in chain
//   order, at most 16 words per input, last_of_run set on the final one.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes
//   chains_per_signature; write it only while the block is idle.
//   The block takes one element at a time. A drain steps through accept,
//   one memory read plus tag compare per released word, a lookup that ends
//   the drain and the frame update; when that last lookup finds a valid
//   slot holding another index, that slot is read before the drain ends.
//   A stalled output holds its word; the drain waits on the hold register
//   and o_in_stall stays high until the drain is done.
//   Reset clears the valid bits, expected index, arrival count and sets
//   chains_per_signature to 67; input and config are held off while reset
//   is asserted. Memory contents are left as they are.
// ============================================================================
module in_order_signature_reorder_window_core #(
    parameter int unsigned WINDOW_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  iosrw_pkg::t_in    i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output iosrw_pkg::t_out   o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [7:0]        i_cfg_data
);

    localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int unsigned MEM_W  = iosrw_pkg::IDX_W + iosrw_pkg::ELEM_W;
    localparam int unsigned LUT_N  = 2 ** iosrw_pkg::IDX_W;

    // ---- index to slot table (constant, built at elaboration) -------------
    logic [SLOT_W-1:0] slot_lut [LUT_N];

    for (genvar g = 0; g < LUT_N; g++) begin : g_lut
        assign slot_lut[g] = SLOT_W'(g % WINDOW_DEPTH);
    end

    // ---- registers -------------------------------------------------------
    iosrw_pkg::t_state            r_state, n_state;
    logic [WINDOW_DEPTH-1:0]      r_valid, n_valid;
    logic [iosrw_pkg::IDX_W-1:0]  r_exp, n_exp;
    logic [iosrw_pkg::IDX_W-1:0]  r_arr, n_arr;
    logic [iosrw_pkg::IDX_W-1:0]  r_cps, n_cps;
    logic [iosrw_pkg::CNT_W-1:0]  r_count, n_count;
    logic                         r_hold_v, n_hold_v;
    iosrw_pkg::t_elem             r_hold, n_hold;
    logic                         r_out_valid, n_out_valid;
    iosrw_pkg::t_out              r_out, n_out;

    // ---- memory port signals ---------------------------------------------
    logic                         ram_we;
    logic                         ram_re;
    logic [MEM_W-1:0]             ram_wdata;
    logic [MEM_W-1:0]             ram_rdata;
    logic [SLOT_W-1:0]            in_slot;
    logic [SLOT_W-1:0]            exp_slot;
    logic [iosrw_pkg::IDX_W-1:0]  rd_tag;
    iosrw_pkg::t_elem             rd_elem;
    iosrw_pkg::t_elem             in_elem;
    logic                         out_free;
    logic                         in_stall;

    assign in_slot  = slot_lut[i_in_data.chain_index];
    assign exp_slot = slot_lut[r_exp];

    assign in_elem.word_0 = i_in_data.word_0;
    assign in_elem.word_1 = i_in_data.word_1;
    assign in_elem.word_2 = i_in_data.word_2;
    assign in_elem.word_3 = i_in_data.word_3;
    assign in_elem.word_4 = i_in_data.word_4;
    assign in_elem.word_5 = i_in_data.word_5;
    assign in_elem.word_6 = i_in_data.word_6;
    assign in_elem.word_7 = i_in_data.word_7;

    assign ram_wdata = {i_in_data.chain_index, in_elem};
    assign rd_tag    = ram_rdata[iosrw_pkg::ELEM_W +: iosrw_pkg::IDX_W];
    assign rd_elem   = iosrw_pkg::t_elem'(ram_rdata[iosrw_pkg::ELEM_W-1:0]);

    // Element memory: tag and body of each window slot. Writes happen only
    // in the accept cycle and reads only in later drain cycles, so a read
    // never races a write to the same slot.
    iosrw_ram #(
        .WIDTH (MEM_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (in_slot),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (exp_slot),
        .o_rdata (ram_rdata)
    );

    // Output register can take a new word when empty or being taken now.
    assign out_free = !r_out_valid || !i_out_stall;

    function automatic iosrw_pkg::t_out make_out(iosrw_pkg::t_elem e, logic last);
        iosrw_pkg::t_out o;
        o.out_word_0  = e.word_0;
        o.out_word_1  = e.word_1;
        o.out_word_2  = e.word_2;
        o.out_word_3  = e.word_3;
        o.out_word_4  = e.word_4;
        o.out_word_5  = e.word_5;
        o.out_word_6  = e.word_6;
        o.out_word_7  = e.word_7;
        o.last_of_run = last;
        return o;
    endfunction

    // ---- next state ------------------------------------------------------
    // A released element first waits in the hold register; it moves to the
    // output once we know whether another one follows, which settles
    // last_of_run.
    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_exp       = r_exp;
        n_arr       = r_arr;
        n_count     = r_count;
        n_hold_v    = r_hold_v;
        n_hold      = r_hold;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        in_stall    = 1'b1;

        case (r_state)
            iosrw_pkg::ST_IDLE: begin
                in_stall = 1'b0;
                if (i_in_valid) begin
                    // store the element, overwriting whatever sat in the slot
                    ram_we           = 1'b1;
                    n_valid[in_slot] = 1'b1;
                    n_count          = '0;
                    n_hold_v         = 1'b0;
                    n_state          = iosrw_pkg::ST_LOOK;
                end
            end
            iosrw_pkg::ST_LOOK: begin
                if (r_count < iosrw_pkg::CNT_W'(iosrw_pkg::MAX_RESULTS) &&
                    r_exp < r_cps && r_valid[exp_slot]) begin
                    ram_re  = 1'b1;
                    n_state = iosrw_pkg::ST_EVAL;
                end else begin
                    n_state = iosrw_pkg::ST_DONE;
                end
            end
            iosrw_pkg::ST_EVAL: begin
                if (rd_tag == r_exp) begin
                    // wait here while a held word cannot advance
                    if (!r_hold_v || out_free) begin
                        if (r_hold_v) begin
                            n_out_valid = 1'b1;
                            n_out       = make_out(r_hold, 1'b0);
                        end
                        n_hold            = rd_elem;
                        n_hold_v          = 1'b1;
                        n_valid[exp_slot] = 1'b0;
                        n_exp             = r_exp + 1'b1;
                        n_count           = r_count + 1'b1;
                        n_state           = iosrw_pkg::ST_LOOK;
                    end
                end else begin
                    n_state = iosrw_pkg::ST_DONE;
                end
            end
            iosrw_pkg::ST_DONE: begin
                if (!r_hold_v || out_free) begin
                    if (r_hold_v) begin
                        n_out_valid = 1'b1;
                        n_out       = make_out(r_hold, 1'b1);
                    end
                    n_hold_v = 1'b0;
                    n_arr    = r_arr + 1'b1;
                    // end of frame: drop the window for the next signature
                    if (n_arr >= r_cps) begin
                        n_valid = '0;
                        n_exp   = '0;
                        n_arr   = '0;
                    end
                    n_state = iosrw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = iosrw_pkg::ST_IDLE;
            end
        endcase
    end

    // Register writes are always taken.
    assign n_cps = i_cfg_valid ? i_cfg_data : r_cps;

    // ---- control registers -----------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iosrw_pkg::ST_IDLE;
            r_valid     <= '0;
            r_exp       <= '0;
            r_arr       <= '0;
            r_cps       <= iosrw_pkg::CPS_RESET;
            r_count     <= '0;
            r_hold_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_exp       <= n_exp;
            r_arr       <= n_arr;
            r_cps       <= n_cps;
            r_count     <= n_count;
            r_hold_v    <= n_hold_v;
            r_out_valid <= n_out_valid;
        end
    end

    // ---- payload registers -----------------------------------------------
    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    // hold off both write channels while reset is asserted
    assign o_in_stall  = in_stall || !i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = i_rst_n;

    // ---- assertions ------------------------------------------------------
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("window memory written and read in one cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= iosrw_pkg::CNT_W'(iosrw_pkg::MAX_RESULTS))
        else $error("drain released more than the per-input limit");

    a_accept_starts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == iosrw_pkg::ST_LOOK && r_count == '0))
        else $error("accepted element did not start a drain");

    a_read_follows_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |-> r_valid[exp_slot])
        else $error("read issued for an empty slot");

    a_done_empty_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == iosrw_pkg::ST_DONE && !r_hold_v) |=> (r_state == iosrw_pkg::ST_IDLE))
        else $error("drain end with nothing held did not return to idle");

endmodule
